### design/mbps_pkg.sv
// ----------------------------------------------------------------------------
// mbps_pkg: shared types and constants for the masked byte pattern search
// Register indexes, the configuration record and the parameter defaults.
// ----------------------------------------------------------------------------
package mbps_pkg;

  // Parameter defaults
  localparam int PATTERN_MAX_DEFAULT = 32;
  localparam int OFFSET_BITS_DEFAULT = 32;

  // Pattern storage is fixed by the register map: four 64-bit words
  localparam int NUM_PATTERN_BYTES = 32;
  localparam int CFG_INDEX_W       = 3;
  localparam int CFG_DATA_W        = 64;
  localparam int OFFSET_OUT_W      = 32;

  // Pattern byte that matches anything in wildcard mode ('?')
  localparam logic [7:0] WILDCARD_BYTE = 8'h3F;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_WORD_0 = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_WORD_1 = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_WORD_2 = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_WORD_3 = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_COMPARE_MASK   = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LENGTH = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_WILDCARD_MODE  = 3'd6;

  // Configuration record; pattern byte j sits in pattern[j]
  typedef struct packed {
    logic [NUM_PATTERN_BYTES-1:0][7:0] pattern;
    logic [31:0]                       compare_mask;
    logic [5:0]                        pattern_length;
    logic                              wildcard_mode;
  } cfg_t;

endpackage

### design/masked_byte_pattern_search.sv
// ----------------------------------------------------------------------------
// masked_byte_pattern_search: masked / wildcard byte signature search
// Streams one region byte per transaction and reports the first match.
// ----------------------------------------------------------------------------
// Takes one byte per clock on the slave stream and gives at most one result
// per region on the master stream. After the byte that decides it is
// accepted, it lands in the window register, the whole window is
// compared against the aligned pattern in parallel and the result goes into
// the output register. s_tready falls only while a byte sits in the window
// stage and the output register holds a result not yet taken. A found result
// carries the region offset of the first matched byte; a region that ends
// without a match gives one result with tuser[0] low and offset zero. The
// configuration port never stalls; write it only while the block is idle.
module masked_byte_pattern_search #(
  parameter int PATTERN_MAX = mbps_pkg::PATTERN_MAX_DEFAULT,
  parameter int OFFSET_BITS = mbps_pkg::OFFSET_BITS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mbps_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [mbps_pkg::CFG_DATA_W-1:0]     cfg_data,
  // byte stream
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [7:0]                          s_tdata,   // [7:0] data_byte
  input  logic                                s_tlast,   // region_end
  // result stream
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [mbps_pkg::OFFSET_OUT_W-1:0]   m_tdata,   // [31:0] match_offset
  output logic [0:0]                          m_tuser    // [0] found
);

  localparam int LEN_W = $clog2(PATTERN_MAX + 1);
  localparam int EXT_W = (OFFSET_BITS > mbps_pkg::OFFSET_OUT_W) ?
                         OFFSET_BITS : mbps_pkg::OFFSET_OUT_W;

  mbps_pkg::cfg_t               cfg;
  logic [LEN_W-1:0]             len_eff;
  logic [PATTERN_MAX-1:0][7:0]  exp_byte;
  logic [PATTERN_MAX-1:0]       care;

  // window stage
  logic [PATTERN_MAX-1:0][7:0]  window;
  logic [LEN_W-1:0]             fill;
  logic [OFFSET_BITS-1:0]       position;
  logic [OFFSET_BITS-1:0]       here;
  logic                         stage_valid;
  logic                         stage_last;
  logic                         matched;

  logic                         in_accept;
  logic                         out_free;
  logic                         stage_go;
  logic                         region_clear;
  logic [PATTERN_MAX-1:0]       slot_ok;
  logic                         hit;
  logic                         miss_end;
  logic [LEN_W-1:0]             fill_base;
  logic [LEN_W-1:0]             fill_next;
  logic [OFFSET_BITS-1:0]       position_base;
  logic [OFFSET_BITS-1:0]       start;
  logic [EXT_W-1:0]             start_ext;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pattern        <= '0;
      cfg.compare_mask   <= '0;
      cfg.pattern_length <= 6'd1;
      cfg.wildcard_mode  <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        mbps_pkg::REG_PATTERN_WORD_0: cfg.pattern[7:0]   <= cfg_data;
        mbps_pkg::REG_PATTERN_WORD_1: cfg.pattern[15:8]  <= cfg_data;
        mbps_pkg::REG_PATTERN_WORD_2: cfg.pattern[23:16] <= cfg_data;
        mbps_pkg::REG_PATTERN_WORD_3: cfg.pattern[31:24] <= cfg_data;
        mbps_pkg::REG_COMPARE_MASK:   cfg.compare_mask   <= cfg_data[31:0];
        mbps_pkg::REG_PATTERN_LENGTH: cfg.pattern_length <= cfg_data[5:0];
        mbps_pkg::REG_WILDCARD_MODE:  cfg.wildcard_mode  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  mbps_align #(
    .PATTERN_MAX (PATTERN_MAX)
  ) u_align (
    .cfg      (cfg),
    .len_eff  (len_eff),
    .exp_byte (exp_byte),
    .care     (care)
  );

  // Handshake
  assign out_free     = !m_tvalid || m_tready;
  assign stage_go     = stage_valid && out_free;
  assign s_tready     = !stage_valid || out_free;
  assign in_accept    = s_tvalid && s_tready;
  assign region_clear = stage_go && stage_last;

  // Parallel window compare
  always_comb begin
    for (int k = 0; k < PATTERN_MAX; k++) begin
      slot_ok[k] = !care[k] || (window[k] == exp_byte[k]);
    end
  end

  assign hit      = !matched && (fill >= len_eff) && (&slot_ok);
  assign miss_end = !hit && !matched && stage_last;

  // Match start offset, wrapped to OFFSET_BITS then fitted to the output
  assign start     = here - (OFFSET_BITS'(len_eff) - OFFSET_BITS'(1));
  assign start_ext = EXT_W'(start);

  // Region counters restart after the last byte leaves the window stage
  assign fill_base     = region_clear ? '0 : fill;
  assign fill_next     = (fill_base == LEN_W'(PATTERN_MAX)) ? fill_base :
                         fill_base + LEN_W'(1);
  assign position_base = region_clear ? '0 : position;

  // Window stage
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
      fill        <= '0;
      position    <= '0;
    end else if (in_accept) begin
      stage_valid <= 1'b1;
      fill        <= fill_next;
      position    <= position_base + OFFSET_BITS'(1);
    end else begin
      if (stage_go) begin
        stage_valid <= 1'b0;
      end
      fill     <= fill_base;
      position <= position_base;
    end
  end

  // Window bytes and item data: entries older than fill are never compared
  always_ff @(posedge clk) begin
    if (in_accept) begin
      window     <= {window[PATTERN_MAX-2:0], s_tdata};
      here       <= position_base;
      stage_last <= s_tlast;
    end
  end

  // Match flag for the current region
  always_ff @(posedge clk) begin
    if (rst) begin
      matched <= 1'b0;
    end else if (region_clear) begin
      matched <= 1'b0;
    end else if (stage_go && hit) begin
      matched <= 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= stage_go && (hit || miss_end);
    end
  end

  always_ff @(posedge clk) begin
    if (stage_go && (hit || miss_end)) begin
      m_tuser <= hit;
      m_tdata <= hit ? start_ext[mbps_pkg::OFFSET_OUT_W-1:0] : '0;
    end
  end

endmodule

### design/mbps_align.sv
// ----------------------------------------------------------------------------
// mbps_align: pattern alignment against the byte window
// Maps the configured pattern onto window slots: slot k (byte k steps ago)
// is compared with pattern byte len-1-k. Depends on configuration only.
// ----------------------------------------------------------------------------
module mbps_align #(
  parameter int PATTERN_MAX = mbps_pkg::PATTERN_MAX_DEFAULT,
  localparam int LEN_W      = $clog2(PATTERN_MAX + 1)
) (
  input  mbps_pkg::cfg_t               cfg,
  output logic [LEN_W-1:0]             len_eff,   // clamped pattern length
  output logic [PATTERN_MAX-1:0][7:0]  exp_byte,  // expected byte per slot
  output logic [PATTERN_MAX-1:0]       care       // slot takes part in compare
);

  logic [6:0]                   len_w;
  logic [PATTERN_MAX-1:0][6:0]  pat_idx;
  logic [PATTERN_MAX-1:0]       in_range;
  logic [PATTERN_MAX-1:0]       idx_valid;

  // Length clamp: zero acts as one, above the window acts as the window
  always_comb begin
    len_w = {1'b0, cfg.pattern_length};
    if (len_w == 7'd0) begin
      len_w = 7'd1;
    end else if (len_w > 7'(PATTERN_MAX)) begin
      len_w = 7'(PATTERN_MAX);
    end
  end

  assign len_eff = len_w[LEN_W-1:0];

  // Per-slot pattern byte and compare enable
  always_comb begin
    for (int k = 0; k < PATTERN_MAX; k++) begin
      pat_idx[k]   = len_w - 7'(k) - 7'd1;
      in_range[k]  = 7'(k) < len_w;
      idx_valid[k] = pat_idx[k] < 7'(mbps_pkg::NUM_PATTERN_BYTES);
      // bytes past the register map read as zero
      exp_byte[k]  = idx_valid[k] ? cfg.pattern[pat_idx[k][4:0]] : 8'd0;
      if (cfg.wildcard_mode) begin
        care[k] = in_range[k] && (exp_byte[k] != mbps_pkg::WILDCARD_BYTE);
      end else begin
        care[k] = in_range[k] && idx_valid[k] && cfg.compare_mask[pat_idx[k][4:0]];
      end
    end
  end

endmodule

### design/mbps_checker.sv
// ----------------------------------------------------------------------------
// mbps_checker: port-level checks for the masked byte pattern search
// Watches the top-level ports and is bound to every instance.
// ----------------------------------------------------------------------------
module mbps_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              s_tvalid,
  input logic                              s_tready,
  input logic                              m_tvalid,
  input logic                              m_tready,
  input logic [mbps_pkg::OFFSET_OUT_W-1:0] m_tdata,
  input logic [0:0]                        m_tuser
);

  // A stalled result transaction holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // A not-found result always reports offset zero
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata == '0)
    else $error("not-found result with nonzero offset");

  // Input stalls only behind an untaken result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready)
    else $error("input stalled with output free");

  // A fresh result follows an earlier accepted byte
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
    else $error("result without a preceding byte");

endmodule

bind masked_byte_pattern_search mbps_checker u_mbps_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

### bench/search_check_pkg.sv
// ----------------------------------------------------------------------------
// search_check_pkg: result tracking for the masked byte pattern search bench
// Holds a model of the search that predicts, for every accepted byte, any
// result it should cause, and compares the results the block delivers.
// ----------------------------------------------------------------------------
package search_check_pkg;

  import mbps_pkg::*;

  localparam int WINDOW_DEPTH = PATTERN_MAX_DEFAULT;

  typedef struct packed {
    logic        found;
    logic [31:0] offset;
  } search_result_t;

  class search_checker;

    // mirror of the register file
    cfg_t           cfg;

    // per-region search state
    logic [7:0]     window [WINDOW_DEPTH];
    logic [31:0]    position;
    int             fill;
    bit             matched;

    // results predicted but not yet seen
    search_result_t awaited_results[$];

    int             mismatches;
    int             bytes_seen;
    int             regions_seen;
    int             hits_checked;
    int             misses_checked;

    function new();
      cfg                = '0;
      cfg.pattern_length = 6'd1;
      clear_region();
    endfunction

    function void clear_region();
      foreach (window[k]) window[k] = 8'h00;
      position = '0;
      fill     = 0;
      matched  = 1'b0;
    endfunction

    // length zero acts as one, anything past the window depth is clipped
    function int active_length();
      int n;
      n = cfg.pattern_length;
      if (n == 0) n = 1;
      if (n > WINDOW_DEPTH) n = WINDOW_DEPTH;
      return n;
    endfunction

    function bit byte_checked(int j);
      if (cfg.wildcard_mode) return cfg.pattern[j] != WILDCARD_BYTE;
      return cfg.compare_mask[j];
    endfunction

    function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
      int w;
      w = idx;
      case (idx)
        REG_PATTERN_WORD_0, REG_PATTERN_WORD_1, REG_PATTERN_WORD_2,
        REG_PATTERN_WORD_3: begin
          for (int k = 0; k < 8; k++) cfg.pattern[8*w+k] = d[8*k +: 8];
        end
        REG_COMPARE_MASK:   cfg.compare_mask   = d[31:0];
        REG_PATTERN_LENGTH: cfg.pattern_length = d[5:0];
        REG_WILDCARD_MODE:  cfg.wildcard_mode  = d[0];
        default: ;
      endcase
    endfunction

    // advance the search by one accepted byte and queue what it should give
    function void scan_byte(logic [7:0] b, logic last);
      int             len;
      logic [31:0]    here;
      bit             hit;
      search_result_t r;
      len  = active_length();
      here = position;
      for (int k = WINDOW_DEPTH - 1; k > 0; k--) window[k] = window[k-1];
      window[0] = b;
      if (fill < WINDOW_DEPTH) fill++;
      position = here + 32'd1;
      bytes_seen++;

      if (!matched && fill >= len) begin
        hit = 1'b1;
        for (int j = 0; j < len; j++)
          if (byte_checked(j) && cfg.pattern[j] != window[len-1-j]) hit = 1'b0;
        if (hit) begin
          matched  = 1'b1;
          r.found  = 1'b1;
          r.offset = here - 32'(len - 1);
          awaited_results.push_back(r);
        end
      end

      if (last) begin
        if (!matched) begin
          r.found  = 1'b0;
          r.offset = '0;
          awaited_results.push_back(r);
        end
        clear_region();
        regions_seen++;
      end
    endfunction

    function void note_error(string msg);
      mismatches++;
      if (mismatches <= 10) $display("MISMATCH: %s", msg);
    endfunction

    function void check_result(logic found, logic [31:0] offset);
      search_result_t want;
      if (awaited_results.size() == 0) begin
        note_error($sformatf("result with none pending: found=%0d offset=0x%08h",
                             found, offset));
        return;
      end
      want = awaited_results.pop_front();
      if (want.found !== found || want.offset !== offset)
        note_error($sformatf("expected found=%0d offset=0x%08h, got found=%0d offset=0x%08h",
                             want.found, want.offset, found, offset));
      if (want.found) hits_checked++;
      else misses_checked++;
    endfunction

  endclass

endpackage

### bench/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench for masked_byte_pattern_search
// Streams directed and random byte regions through the block under several
// pattern setups in mask and wildcard mode, predicts each region's result in
// a checker object and compares every result transaction field by field.
// ----------------------------------------------------------------------------
module tb;

  import mbps_pkg::*;
  import search_check_pkg::*;

  // index past the register list, writes to it are dropped
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 40;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_LIMIT = 5000;
  localparam int SETTLE      = 8;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [7:0]             s_tdata;   // [7:0] data_byte
  logic                   s_tlast;   // region_end
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OFFSET_OUT_W-1:0] m_tdata;  // [31:0] match_offset
  logic [0:0]             m_tuser;   // [0] found

  search_checker sb;
  bit            idle_enabled = 1'b1;
  bit            hold_request = 1'b0;

  masked_byte_pattern_search uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // hard stop in case the block hangs
  initial begin
    #400000;
    $display("RESULT: ERROR");
    $finish;
  end

  // result receiver: random back-pressure plus one long hold on request
  initial begin
    int hold_left;
    hold_left = 0;
    m_tready  = 1'b1;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        m_tready = 1'b0;
        hold_left--;
      end else begin
        m_tready = !(idle_enabled && $urandom_range(0, 99) < 7);
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tuser[0], m_tdata);
  end

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] d);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = d;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, d);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic send_byte(input logic [7:0] b, input logic last);
    while (idle_enabled && $urandom_range(0, 99) < 7) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = b;
    s_tlast  = last;
    do @(posedge clk); while (!s_tready);
    sb.scan_byte(b, last);
    @(negedge clk);
  endtask

  // stop sending, wait for every pending result, then let the pipe settle
  task automatic drain();
    int waited;
    waited   = 0;
    s_tvalid = 1'b0;
    while (sb.awaited_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    repeat (SETTLE) @(negedge clk);
  endtask

  // random regions, most of them carrying a planted copy of the pattern
  task automatic run_phase(input int n_items);
    int         sent;
    int         len;
    int         rlen;
    int         start;
    int         j;
    bit         plant;
    logic [7:0] region[$];
    sent = 0;
    while (sent < n_items) begin
      len = sb.active_length();
      case ($urandom_range(0, 9))
        0:       rlen = $urandom_range(1, len);
        1:       rlen = $urandom_range(1, 3);
        default: rlen = $urandom_range(len, len + 10);
      endcase
      plant = ($urandom_range(0, 9) < 7) && (rlen >= len);
      region.delete();
      for (int i = 0; i < rlen; i++)
        region.push_back(($urandom_range(0, 3) == 0)
                         ? sb.cfg.pattern[$urandom_range(0, len - 1)]
                         : 8'($urandom_range(0, 255)));
      if (plant) begin
        start = $urandom_range(0, rlen - len);
        for (int k = 0; k < len; k++)
          if (sb.byte_checked(k)) region[start+k] = sb.cfg.pattern[k];
        // now and then break the copy by one bit
        if ($urandom_range(0, 4) == 0) begin
          j = $urandom_range(0, len - 1);
          region[start+j] = region[start+j] ^ (8'h01 << $urandom_range(0, 7));
        end
      end
      foreach (region[i]) send_byte(region[i], i == rlen - 1);
      sent += rlen;
    end
  endtask

  // fresh register setup for one random phase; early phases hit the extremes
  task automatic configure_phase(input int p);
    logic [CFG_DATA_W-1:0] word;
    logic [5:0]            len_code;
    logic [31:0]           mask;
    logic                  mode;
    case (p)
      0:       len_code = 6'd32;
      1:       len_code = 6'($urandom_range(33, 63));
      2:       len_code = 6'd0;
      default: len_code = 6'($urandom_range(1, 8));
    endcase
    case (p)
      0:       mask = 32'hFFFF_FFFF;
      6:       mask = 32'h0000_0000;
      default: mask = $urandom;
    endcase
    mode = (p == 0) ? 1'b0 : (p == 1) ? 1'b1 : 1'($urandom_range(0, 1));
    for (int w = 0; w < 4; w++) begin
      for (int k = 0; k < 8; k++)
        word[8*k +: 8] = ($urandom_range(0, 3) == 0) ? WILDCARD_BYTE
                                                     : 8'($urandom_range(0, 255));
      if (p == 6) word = '1;
      case (w)
        0: write_reg(REG_PATTERN_WORD_0, word);
        1: write_reg(REG_PATTERN_WORD_1, word);
        2: write_reg(REG_PATTERN_WORD_2, word);
        default: write_reg(REG_PATTERN_WORD_3, word);
      endcase
    end
    write_reg(REG_COMPARE_MASK, {32'h0, mask});
    write_reg(REG_PATTERN_LENGTH, {58'h0, len_code});
    write_reg(REG_WILDCARD_MODE, {63'h0, mode});
  endtask

  initial begin
    rst       = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tlast   = 1'b0;
    sb        = new();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset setup: one-byte pattern with nothing compared, first byte hits,
    // the rest of the region and its end stay silent
    send_byte(8'hAA, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    drain();

    // all-ones pattern under a full mask; a write past the list is dropped
    write_reg(REG_PATTERN_WORD_0, '1);
    write_reg(REG_COMPARE_MASK, 64'hFFFF_FFFF);
    write_reg(REG_PATTERN_LENGTH, 64'd4);
    write_reg(REG_UNUSED, 64'h0123_4567_89AB_CDEF);
    // region shorter than the pattern, then a match on the last byte
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);
    drain();

    // length zero behaves as one
    write_reg(REG_PATTERN_WORD_0, 64'hFFFF_FFFF_FFFF_FF00);
    write_reg(REG_PATTERN_LENGTH, 64'd0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
    drain();

    // wildcard pattern "A?C": one hit, one miss
    write_reg(REG_PATTERN_WORD_0, 64'h0000_0000_0043_3F41);
    write_reg(REG_WILDCARD_MODE, 64'd1);
    write_reg(REG_PATTERN_LENGTH, 64'd3);
    send_byte(8'h41, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h43, 1'b1);
    send_byte(8'h41, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h44, 1'b1);
    drain();

    // setup change in the middle of a region applies from the next byte on
    send_byte(8'h41, 1'b0);
    drain();
    write_reg(REG_PATTERN_LENGTH, 64'd1);
    send_byte(8'h41, 1'b1);
    drain();

    // random phases; one with a long result hold, one with no idling
    for (int p = 0; p < PHASES; p++) begin
      configure_phase(p);
      if (p == 3) hold_request = 1'b1;
      idle_enabled = (p != 5);
      run_phase(PHASE_ITEMS);
      drain();
    end
    idle_enabled = 1'b1;

    if (sb.awaited_results.size() != 0)
      $display("%0d expected results never arrived", sb.awaited_results.size());
    $display("Scanned %0d bytes in %0d regions; checked %0d hits and %0d misses",
             sb.bytes_seen, sb.regions_seen, sb.hits_checked, sb.misses_checked);
    $display("Mismatches: %0d", sb.mismatches);
    if (sb.mismatches == 0 && sb.awaited_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
